// ===== design/tpa_pkg.sv =====
package tpa_pkg;

    // Command codes carried on the command field.
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_REQUEST = 2'd2;

    // Geometry of the ownership table and the pad/candidate tables.
    localparam int ENTRIES   = 16;
    localparam int ENTRY_W   = 4;
    localparam int OWNER_W   = 7;
    localparam int PAD_W     = 6;
    localparam int SIG_W     = 5;
    localparam int NUM_CAND  = 4;
    localparam int CAND_W    = 2;
    localparam int CAND_BITS = 5;

    // An owner entry of all ones is minus one, which marks the entry free.
    localparam logic [OWNER_W-1:0] OWNER_FREE = {OWNER_W{1'b1}};

    // Candidate code layout: OUT2 select, segment, timer number.
    localparam int CAND_OUT2_BIT = 4;
    localparam int CAND_SEG_BIT  = 3;

    // Write controls for the ownership table.
    typedef struct packed {
        logic                clear;
        logic                wr_en;
        logic [ENTRY_W-1:0]  wr_idx;
        logic [OWNER_W-1:0]  wr_owner;
    } tbl_ctrl_t;

    // Result of looking a pad up in the pad table.
    typedef struct packed {
        logic             hit;
        logic [SIG_W-1:0] sig;
    } pad_hit_t;

    // Candidate timer outputs of each signal, four per signal in scan order.
    localparam logic [CAND_BITS-1:0] CAND_ROM [NUM_CAND * 32] = '{
        5'd0,  5'd26, 5'd21, 5'd6,
        5'd16, 5'd0,  5'd5,  5'd31,
        5'd8,  5'd25, 5'd30, 5'd7,
        5'd24, 5'd8,  5'd1,  5'd6,
        5'd1,  5'd18, 5'd21, 5'd13,
        5'd17, 5'd1,  5'd14, 5'd7,
        5'd9,  5'd1,  5'd29, 5'd15,
        5'd25, 5'd9,  5'd13, 5'd7,
        5'd2,  5'd19, 5'd20, 5'd14,
        5'd18, 5'd2,  5'd4,  5'd8,
        5'd10, 5'd27, 5'd28, 5'd6,
        5'd26, 5'd10, 5'd12, 5'd29,
        5'd3,  5'd9,  5'd24, 5'd30,
        5'd19, 5'd3,  5'd6,  5'd28,
        5'd11, 5'd9,  5'd31, 5'd7,
        5'd27, 5'd11, 5'd7,  5'd20,
        5'd4,  5'd0,  5'd16, 5'd27,
        5'd20, 5'd15, 5'd4,  5'd17,
        5'd12, 5'd8,  5'd0,  5'd19,
        5'd28, 5'd2,  5'd12, 5'd25,
        5'd5,  5'd1,  5'd17, 5'd26,
        5'd21, 5'd1,  5'd13, 5'd16,
        5'd13, 5'd6,  5'd1,  5'd18,
        5'd29, 5'd7,  5'd5,  5'd24,
        5'd6,  5'd2,  5'd1,  5'd25,
        5'd28, 5'd10, 5'd6,  5'd18,
        5'd14, 5'd10, 5'd5,  5'd17,
        5'd30, 5'd1,  5'd14, 5'd26,
        5'd7,  5'd3,  5'd21, 5'd24,
        5'd29, 5'd1,  5'd7,  5'd19,
        5'd15, 5'd11, 5'd20, 5'd16,
        5'd31, 5'd6,  5'd15, 5'd27
    };

    // Maps a pad number to its signal; pads without a signal miss.
    function automatic pad_hit_t pad_lookup(input logic [PAD_W-1:0] pad);
        pad_hit_t r;
        r.hit = 1'b1;
        r.sig = '0;
        case (pad)
            6'd12: r.sig = 5'd0;
            6'd25: r.sig = 5'd1;
            6'd13: r.sig = 5'd2;
            6'd26: r.sig = 5'd3;
            6'd18: r.sig = 5'd4;
            6'd27: r.sig = 5'd5;
            6'd19: r.sig = 5'd6;
            6'd28: r.sig = 5'd7;
            6'd5:  r.sig = 5'd8;
            6'd29: r.sig = 5'd9;
            6'd6:  r.sig = 5'd10;
            6'd30: r.sig = 5'd11;
            6'd22: r.sig = 5'd12;
            6'd31: r.sig = 5'd13;
            6'd23: r.sig = 5'd14;
            6'd32: r.sig = 5'd15;
            6'd42: r.sig = 5'd16;
            6'd4:  r.sig = 5'd17;
            6'd43: r.sig = 5'd18;
            6'd7:  r.sig = 5'd19;
            6'd44: r.sig = 5'd20;
            6'd24: r.sig = 5'd21;
            6'd45: r.sig = 5'd22;
            6'd33: r.sig = 5'd23;
            6'd46: r.sig = 5'd24;
            6'd39: r.sig = 5'd25;
            6'd47: r.sig = 5'd26;
            6'd35: r.sig = 5'd27;
            6'd48: r.sig = 5'd28;
            6'd37: r.sig = 5'd29;
            6'd49: r.sig = 5'd30;
            6'd11: r.sig = 5'd31;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/tpa_owner_table.sv =====
module tpa_owner_table
    import tpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tbl_ctrl_t          ctrl,
    input  logic [ENTRY_W-1:0] rd_idx,
    output logic [OWNER_W-1:0] rd_owner
);

    logic [OWNER_W-1:0] owner_reg [ENTRIES];
    logic [OWNER_W-1:0] wr_value;

    // Any negative owner saturates to minus one, which frees the entry.
    assign wr_value = ctrl.wr_owner[OWNER_W-1] ? OWNER_FREE : ctrl.wr_owner;

    // Table storage: clear all at once, or write one entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                owner_reg[i] <= OWNER_FREE;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                owner_reg[i] <= OWNER_FREE;
            end
        end
        else if (ctrl.wr_en)
        begin
            owner_reg[ctrl.wr_idx] <= wr_value;
        end
    end

    // Single read port used by the candidate scan.
    assign rd_owner = owner_reg[rd_idx];

endmodule

// ===== design/timer_output_pin_allocator_unit.sv =====
// Timer output pin allocator.
// Input channel (in_valid / in_stall) takes one request per handshake: a
// clear of the whole ownership table, a write of one owner entry, or an
// allocation request for a pad. Clear and write complete in the cycle they
// are accepted and produce no result; the input stays open for the next one.
// An allocation request closes the input (in_stall high) while the single
// table read port checks the pad's candidate timer outputs, one per cycle.
// The pad is looked up on the accepting edge; the candidates are then
// scanned in order until one qualifies or all have been tried, and the
// result is loaded into the output register. An unknown pad skips the scan.
// The input reopens in the same cycle that the result is loaded, so a new
// allocation request is taken only once the last one's result is loaded.
// Output channel (out_valid / out_stall) presents granted, grant_segment,
// grant_number and second_output from a register; a stalled result holds.
// If the receiver stalls, the next finished result waits in the sequencer
// until the output register frees, and the input stays closed meanwhile.
// Reset marks every table entry free and empties the output register.
module timer_output_pin_allocator_unit
    import tpa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic [PAD_W-1:0]          pad_number,
    input  logic                      segment_select,
    input  logic [2:0]                timer_select,
    input  logic signed [OWNER_W-1:0] owner_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      granted,
    output logic                      grant_segment,
    output logic [2:0]                grant_number,
    output logic                      second_output
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [PAD_W-1:0]     pad_reg, pad_next;
    logic [SIG_W-1:0]     sig_reg, sig_next;
    logic [CAND_W-1:0]    idx_reg, idx_next;
    logic                 res_granted_reg, res_granted_next;
    logic [CAND_BITS-1:0] res_cand_reg, res_cand_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_granted_reg, out_granted_next;
    logic [CAND_BITS-1:0] out_cand_reg, out_cand_next;

    logic                 in_accept;
    logic                 out_free;
    pad_hit_t             lookup;
    logic [CAND_BITS-1:0] cand;
    logic [OWNER_W-1:0]   cur_owner;
    logic                 qualifies;
    tbl_ctrl_t            tbl_ctrl;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign lookup = pad_lookup(pad_number);
    assign cand   = CAND_ROM[{sig_reg, idx_reg}];

    // A candidate qualifies when it is free or already owned by this pad.
    assign qualifies = cur_owner[OWNER_W-1] || (cur_owner == {1'b0, pad_reg});

    // Table write controls: commands from the input, or a grant from the scan.
    always_comb
    begin
        tbl_ctrl = '0;
        if (in_accept)
        begin
            unique case (command)
                CMD_CLEAR:
                begin
                    tbl_ctrl.clear = 1'b1;
                end
                CMD_WRITE:
                begin
                    tbl_ctrl.wr_en    = 1'b1;
                    tbl_ctrl.wr_idx   = {segment_select, timer_select};
                    tbl_ctrl.wr_owner = owner_value;
                end
                default:
                begin
                    tbl_ctrl = '0;
                end
            endcase
        end
        else if ((state_reg == ST_SCAN) && qualifies)
        begin
            tbl_ctrl.wr_en    = 1'b1;
            tbl_ctrl.wr_idx   = cand[ENTRY_W-1:0];
            tbl_ctrl.wr_owner = {1'b0, pad_reg};
        end
    end

    tpa_owner_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (tbl_ctrl),
        .rd_idx   (cand[ENTRY_W-1:0]),
        .rd_owner (cur_owner)
    );

    // Sequencer: lookup on acceptance, scan one candidate a cycle, hand over.
    always_comb
    begin
        state_next       = state_reg;
        pad_next         = pad_reg;
        sig_next         = sig_reg;
        idx_next         = idx_reg;
        res_granted_next = res_granted_reg;
        res_cand_next    = res_cand_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_granted_next = out_granted_reg;
        out_cand_next    = out_cand_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (command == CMD_REQUEST))
                begin
                    pad_next         = pad_number;
                    sig_next         = lookup.sig;
                    idx_next         = '0;
                    res_granted_next = 1'b0;
                    res_cand_next    = '0;
                    state_next       = lookup.hit ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (qualifies)
                begin
                    res_granted_next = 1'b1;
                    res_cand_next    = cand;
                    state_next       = ST_FINISH;
                end
                else if (idx_reg == CAND_W'(NUM_CAND - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + CAND_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_cand_next    = res_cand_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        pad_reg         <= pad_next;
        sig_reg         <= sig_next;
        idx_reg         <= idx_next;
        res_granted_reg <= res_granted_next;
        res_cand_reg    <= res_cand_next;
        out_granted_reg <= out_granted_next;
        out_cand_reg    <= out_cand_next;
    end

    // Result fields are slices of the registered candidate code.
    assign out_valid     = out_valid_reg;
    assign granted       = out_granted_reg;
    assign grant_segment = out_cand_reg[CAND_SEG_BIT];
    assign grant_number  = out_cand_reg[2:0];
    assign second_output = out_cand_reg[CAND_OUT2_BIT];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

import tpa_pkg::*;

// One allocation result as it leaves the block.
typedef struct packed {
    logic       granted;
    logic       segment;
    logic [2:0] number;
    logic       out2;
} grant_t;

// Shadow of the ownership table and the queue of grants still to arrive.
class grant_scoreboard;
    logic signed [OWNER_W-1:0] owner_of [ENTRIES];
    grant_t                    pending_grants [$];
    int                        mismatches;
    int                        grants;
    int                        refusals;
    int                        writes;
    int                        clears;
    int                        unused_cmds;

    function new();
        mismatches  = 0;
        grants      = 0;
        refusals    = 0;
        writes      = 0;
        clears      = 0;
        unused_cmds = 0;
        free_all();
    endfunction

    function void free_all();
        foreach (owner_of[i])
        begin
            owner_of[i] = OWNER_FREE;
        end
    endfunction

    // Signal routed to each pad; pads with no signal give -1.
    function int signal_of(logic [PAD_W-1:0] pad);
        case (pad)
            6'd12: return 0;
            6'd25: return 1;
            6'd13: return 2;
            6'd26: return 3;
            6'd18: return 4;
            6'd27: return 5;
            6'd19: return 6;
            6'd28: return 7;
            6'd5:  return 8;
            6'd29: return 9;
            6'd6:  return 10;
            6'd30: return 11;
            6'd22: return 12;
            6'd31: return 13;
            6'd23: return 14;
            6'd32: return 15;
            6'd42: return 16;
            6'd4:  return 17;
            6'd43: return 18;
            6'd7:  return 19;
            6'd44: return 20;
            6'd24: return 21;
            6'd45: return 22;
            6'd33: return 23;
            6'd46: return 24;
            6'd39: return 25;
            6'd47: return 26;
            6'd35: return 27;
            6'd48: return 28;
            6'd37: return 29;
            6'd49: return 30;
            6'd11: return 31;
            default: return -1;
        endcase
    endfunction

    // Four candidate codes per signal, first in the top bits. A code holds
    // the OUT2 select in bit 4, the segment in bit 3 and the timer below.
    function logic [19:0] candidates_of(int sig);
        case (sig)
            0:  return {5'd0,  5'd26, 5'd21, 5'd6};
            1:  return {5'd16, 5'd0,  5'd5,  5'd31};
            2:  return {5'd8,  5'd25, 5'd30, 5'd7};
            3:  return {5'd24, 5'd8,  5'd1,  5'd6};
            4:  return {5'd1,  5'd18, 5'd21, 5'd13};
            5:  return {5'd17, 5'd1,  5'd14, 5'd7};
            6:  return {5'd9,  5'd1,  5'd29, 5'd15};
            7:  return {5'd25, 5'd9,  5'd13, 5'd7};
            8:  return {5'd2,  5'd19, 5'd20, 5'd14};
            9:  return {5'd18, 5'd2,  5'd4,  5'd8};
            10: return {5'd10, 5'd27, 5'd28, 5'd6};
            11: return {5'd26, 5'd10, 5'd12, 5'd29};
            12: return {5'd3,  5'd9,  5'd24, 5'd30};
            13: return {5'd19, 5'd3,  5'd6,  5'd28};
            14: return {5'd11, 5'd9,  5'd31, 5'd7};
            15: return {5'd27, 5'd11, 5'd7,  5'd20};
            16: return {5'd4,  5'd0,  5'd16, 5'd27};
            17: return {5'd20, 5'd15, 5'd4,  5'd17};
            18: return {5'd12, 5'd8,  5'd0,  5'd19};
            19: return {5'd28, 5'd2,  5'd12, 5'd25};
            20: return {5'd5,  5'd1,  5'd17, 5'd26};
            21: return {5'd21, 5'd1,  5'd13, 5'd16};
            22: return {5'd13, 5'd6,  5'd1,  5'd18};
            23: return {5'd29, 5'd7,  5'd5,  5'd24};
            24: return {5'd6,  5'd2,  5'd1,  5'd25};
            25: return {5'd28, 5'd10, 5'd6,  5'd18};
            26: return {5'd14, 5'd10, 5'd5,  5'd17};
            27: return {5'd30, 5'd1,  5'd14, 5'd26};
            28: return {5'd7,  5'd3,  5'd21, 5'd24};
            29: return {5'd29, 5'd1,  5'd7,  5'd19};
            30: return {5'd15, 5'd11, 5'd20, 5'd16};
            default: return {5'd31, 5'd6,  5'd15, 5'd27};
        endcase
    endfunction

    // Applies one accepted request to the shadow table; an allocation request also queues its grant.
    function void note_request(logic [1:0] cmd, logic [PAD_W-1:0] pad, logic seg,
                               logic [2:0] tmr, logic signed [OWNER_W-1:0] owner);
        grant_t      result;
        int          sig;
        logic [19:0] cands;
        logic [4:0]  code;
        result = '0;
        if (cmd == CMD_CLEAR)
        begin
            free_all();
            clears++;
        end
        else if (cmd == CMD_WRITE)
        begin
            // Anything below minus one frees the entry.
            if (owner < $signed(OWNER_FREE))
                owner = OWNER_FREE;
            owner_of[{seg, tmr}] = owner;
            writes++;
        end
        else if (cmd == CMD_REQUEST)
        begin
            sig = signal_of(pad);
            if (sig >= 0)
            begin
                cands = candidates_of(sig);
                // First candidate that is free or already held by this pad wins.
                for (int k = 0; k < NUM_CAND; k++)
                begin
                    code = cands[19 - 5 * k -: 5];
                    if (!result.granted && (owner_of[code[3:0]] < 0 ||
                        owner_of[code[3:0]] == $signed({1'b0, pad})))
                    begin
                        owner_of[code[3:0]] = {1'b0, pad};
                        result.granted = 1'b1;
                        result.segment = code[3];
                        result.number  = code[2:0];
                        result.out2    = code[4];
                    end
                end
            end
            if (result.granted)
                grants++;
            else
                refusals++;
            pending_grants.push_back(result);
        end
        else
        begin
            unused_cmds++;
        end
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Compares one delivered result with the oldest grant still expected.
    task check_result(grant_t got);
        grant_t want;
        if (pending_grants.size() == 0)
        begin
            report_mismatch($sformatf("result with no request waiting (granted=%0b)",
                                      got.granted));
        end
        else
        begin
            want = pending_grants.pop_front();
            if (got.granted !== want.granted)
                report_mismatch($sformatf("granted %0b, wanted %0b",
                                          got.granted, want.granted));
            if (got.segment !== want.segment)
                report_mismatch($sformatf("grant_segment %0b, wanted %0b",
                                          got.segment, want.segment));
            if (got.number !== want.number)
                report_mismatch($sformatf("grant_number %0d, wanted %0d",
                                          got.number, want.number));
            if (got.out2 !== want.out2)
                report_mismatch($sformatf("second_output %0b, wanted %0b",
                                          got.out2, want.out2));
        end
    endtask

    function int outstanding();
        return pending_grants.size();
    endfunction
endclass

module testbench;

    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam int         LONG_HOLD_CYCLES = 150;
    localparam int         WATCHDOG_LIMIT   = 1000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                command;
    logic [PAD_W-1:0]          pad_number;
    logic                      segment_select;
    logic [2:0]                timer_select;
    logic signed [OWNER_W-1:0] owner_value;
    logic                      out_valid;
    logic                      out_stall;
    logic                      granted;
    logic                      grant_segment;
    logic [2:0]                grant_number;
    logic                      second_output;

    grant_scoreboard sb;
    bit              quiet_phase = 1'b0;
    bit              long_hold_req = 1'b0;

    timer_output_pin_allocator_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .pad_number     (pad_number),
        .segment_select (segment_select),
        .timer_select   (timer_select),
        .owner_value    (owner_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted        (granted),
        .grant_segment  (grant_segment),
        .grant_number   (grant_number),
        .second_output  (second_output)
    );

    always #2 clk = ~clk;

    // Both handshakes are sampled on the edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(command, pad_number, segment_select, timer_select, owner_value);
        if (rst_n && out_valid && !out_stall)
            sb.check_result({granted, grant_segment, grant_number, second_output});
    end

    // Result side: random stall bursts, one long hold-off on demand, none at the end.
    initial
    begin : receiver
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Ends the run if neither side completes a handshake for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no request moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Offers one request and returns on the edge that accepts it.
    task automatic send_item(logic [1:0] cmd, logic [PAD_W-1:0] pad, logic seg,
                             logic [2:0] tmr, logic signed [OWNER_W-1:0] owner);
        in_valid       <= 1'b1;
        command        <= cmd;
        pad_number     <= pad;
        segment_select <= seg;
        timer_select   <= tmr;
        owner_value    <= owner;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Mostly requests for routed pads, with writes, clears and noise mixed in.
    task automatic send_random(bit with_gaps);
        logic [1:0]                cmd;
        logic [PAD_W-1:0]          pad;
        logic                      seg;
        logic [2:0]                tmr;
        logic signed [OWNER_W-1:0] owner;
        int                        pick;
        pad   = PAD_W'($urandom);
        seg   = 1'($urandom);
        tmr   = 3'($urandom);
        owner = OWNER_W'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 4)
        begin
            cmd = CMD_CLEAR;
        end
        else if (pick < 16)
        begin
            cmd = CMD_WRITE;
            case ($urandom_range(0, 2))
                0: owner = OWNER_FREE;
                1: owner = {1'b0, pad};
                default: ;
            endcase
        end
        else if (pick < 18)
        begin
            cmd = CMD_UNUSED;
        end
        else
        begin
            cmd = CMD_REQUEST;
            if (pick < 88)
            begin
                while (sb.signal_of(pad) < 0)
                    pad = PAD_W'($urandom);
            end
        end
        if (with_gaps && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 13));
        send_item(cmd, pad, seg, tmr, owner);
    endtask

    initial
    begin : stimulus
        sb = new();
        in_valid       <= 1'b0;
        command        <= CMD_CLEAR;
        pad_number     <= '0;
        segment_select <= 1'b0;
        timer_select   <= '0;
        owner_value    <= '0;
        rst_n          <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fresh table: first grant, a repeat by the same owner, then a second pad.
        send_item(CMD_REQUEST, 6'd12, 1'b1, 3'd7, -7'sd64);
        send_item(CMD_REQUEST, 6'd12, 1'b0, 3'd0, 7'sd63);
        send_item(CMD_REQUEST, 6'd25, 1'b1, 3'd3, 7'sd0);
        // Pads with no signal at both ends of the range.
        send_item(CMD_REQUEST, 6'd0, 1'b0, 3'd0, 7'sd0);
        send_item(CMD_REQUEST, 6'd63, 1'b1, 3'd7, -7'sd1);
        // Take every candidate of the first signal away, so its pad is refused.
        send_item(CMD_WRITE, 6'd63, 1'b0, 3'd0, 7'sd63);
        send_item(CMD_WRITE, 6'd0, 1'b1, 3'd2, 7'sd63);
        send_item(CMD_WRITE, 6'd12, 1'b0, 3'd5, 7'sd0);
        send_item(CMD_WRITE, 6'd12, 1'b0, 3'd6, 7'sd62);
        send_item(CMD_REQUEST, 6'd12, 1'b0, 3'd0, 7'sd0);
        // The most negative owner saturates to free, which lets the pad back in.
        send_item(CMD_WRITE, 6'd0, 1'b0, 3'd6, -7'sd64);
        send_item(CMD_REQUEST, 6'd12, 1'b1, 3'd1, 7'sd5);
        send_item(CMD_WRITE, 6'd63, 1'b1, 3'd7, OWNER_FREE);
        send_item(CMD_UNUSED, 6'd63, 1'b1, 3'd7, -7'sd1);
        send_item(CMD_REQUEST, 6'd11, 1'b0, 3'd4, 7'sd17);
        send_item(CMD_REQUEST, 6'd49, 1'b1, 3'd2, 7'sd40);
        send_item(CMD_CLEAR, 6'd42, 1'b1, 3'd5, 7'sd21);
        send_item(CMD_REQUEST, 6'd12, 1'b0, 3'd0, 7'sd0);
        send_item(CMD_REQUEST, 6'd5, 1'b0, 3'd0, 7'sd0);
        send_item(CMD_WRITE, 6'd11, 1'b1, 3'd7, 7'sd63);
        send_item(CMD_REQUEST, 6'd11, 1'b1, 3'd6, -7'sd33);

        // Random traffic with idling on both sides.
        repeat (250) send_random(1'b1);

        // Receiver holds off while requests keep coming, so the block backs up.
        long_hold_req = 1'b1;
        repeat (16) send_item(CMD_REQUEST, PAD_W'($urandom), 1'($urandom),
                              3'($urandom), OWNER_W'($urandom));

        // Sender waits until every outstanding request has been answered.
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);

        repeat (240) send_random(1'b1);

        // Closing stretch at full rate with no stalls.
        quiet_phase = 1'b1;
        repeat (120) send_random(1'b0);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Allocation requests answered: %0d granted, %0d refused.",
                 sb.grants, sb.refusals);
        $display("Also sent %0d owner writes, %0d clears and %0d unused commands.",
                 sb.writes, sb.clears, sb.unused_cmds);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
